FILE: src/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// If the antecedent holds, the consequent must hold in the following cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/ssev_pkg.sv
`default_nettype none
package ssev_pkg;

  localparam int CACHE_SLOTS_DEF = 8;
  localparam int LINE_PIXELS_DEF = 240;

  localparam logic [7:0] MAIN_WIN_MASK = 8'h0F;
  localparam logic [7:0] SUB_WIN_MASK  = 8'hF0;

  typedef struct packed {
    logic [7:0]         scanline;
    logic [1:0]         wanted_type;
    logic signed [15:0] sprite_x;
    logic signed [15:0] sprite_y;
    logic [7:0]         sprite_width;
    logic [7:0]         sprite_height;
    logic               sprite_enabled;
    logic               double_size;
    logic [1:0]         sprite_type;
    logic [7:0]         window_bits;
    logic               first_sprite;
    logic               last_sprite;
  } sprite_rec_t;

  typedef struct packed {
    logic       selected;
    logic [2:0] slot;
    logic [3:0] selected_count;
    logic       cache_full;
  } eval_result_t;

endpackage
`default_nettype wire

FILE: src/ssev_match.sv
`default_nettype none
module ssev_match #(
  parameter int LINE_PIXELS = ssev_pkg::LINE_PIXELS_DEF
) (
  input  ssev_pkg::sprite_rec_t rec,
  output logic                  hit
);
  import ssev_pkg::*;

  localparam logic signed [17:0] LINE_LIMIT = 18'(LINE_PIXELS);

  logic [8:0]         w_eff;
  logic [8:0]         h_eff;
  logic signed [17:0] sx;
  logic signed [17:0] sy;
  logic signed [17:0] line;
  logic signed [17:0] line_top;
  logic signed [17:0] neg_w;
  logic               window_on;
  logic               vert;
  logic               horiz;

  always_comb begin
    w_eff = rec.double_size ? {rec.sprite_width, 1'b0}  : {1'b0, rec.sprite_width};
    h_eff = rec.double_size ? {rec.sprite_height, 1'b0} : {1'b0, rec.sprite_height};
    sx = {{2{rec.sprite_x[15]}}, rec.sprite_x};
    sy = {{2{rec.sprite_y[15]}}, rec.sprite_y};
    line = {10'd0, rec.scanline};
    // Exclusive lower bound on sprite_y for the sprite to cover this line.
    line_top = line - {9'd0, h_eff};
    neg_w = -{9'd0, w_eff};

    window_on = ((rec.window_bits & MAIN_WIN_MASK) != 8'd0) ||
                ((rec.window_bits & SUB_WIN_MASK) != 8'd0);
    vert  = (sy <= line) && (sy > line_top);
    horiz = (sx < LINE_LIMIT) && (sx > neg_w);

    hit = rec.sprite_enabled && (rec.sprite_type == rec.wanted_type) &&
          window_on && vert && horiz;
  end

endmodule
`default_nettype wire

FILE: src/ssev_count.sv
`default_nettype none
module ssev_count #(
  parameter int CACHE_SLOTS = ssev_pkg::CACHE_SLOTS_DEF
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    advance,
  input  wire                    first,
  input  wire                    hit,
  output ssev_pkg::eval_result_t result
);
  import ssev_pkg::*;

  localparam int CW = $clog2(CACHE_SLOTS + 1);
  localparam logic [CW-1:0] SLOTS = CW'(CACHE_SLOTS);

  logic [CW-1:0] line_count;
  logic [CW-1:0] line_count_next;
  logic [CW-1:0] base;
  logic          sel;
  logic [CW+3:0] base_ext;
  logic [CW+3:0] next_ext;

  always_comb begin
    base = first ? '0 : line_count;
    sel = hit && (base < SLOTS);
    line_count_next = base + CW'(sel);
    base_ext = {4'd0, base};
    next_ext = {4'd0, line_count_next};

    // Slot and count are reported masked to their field widths.
    result.selected       = sel;
    result.slot           = sel ? base_ext[2:0] : 3'd0;
    result.selected_count = next_ext[3:0];
    result.cache_full     = (line_count_next >= SLOTS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count <= '0;
    end else if (advance) begin
      line_count <= line_count_next;
    end
  end

endmodule
`default_nettype wire

FILE: src/scanline_sprite_evaluation_top.sv
// Results are registered: a record passes through the input register and then the result register.
// Throughput: one sprite record per cycle while out_ready does not stall the result register.
// An empty input register still accepts a record; once it is full, a stalled result drops in_ready in the same cycle.
// Reset (rst, synchronous, active high) empties both stages and clears the slot count.
`default_nettype none
`include "assert_macros.svh"
module scanline_sprite_evaluation_top #(
  parameter int CACHE_SLOTS = ssev_pkg::CACHE_SLOTS_DEF,
  parameter int LINE_PIXELS = ssev_pkg::LINE_PIXELS_DEF
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire         [7:0] scanline,
  input  wire         [1:0] wanted_type,
  input  wire signed [15:0] sprite_x,
  input  wire signed [15:0] sprite_y,
  input  wire         [7:0] sprite_width,
  input  wire         [7:0] sprite_height,
  input  wire               sprite_enabled,
  input  wire               double_size,
  input  wire         [1:0] sprite_type,
  input  wire         [7:0] window_bits,
  input  wire               first_sprite,
  input  wire               last_sprite,
  output logic              out_valid,
  input  wire               out_ready,
  output logic              selected,
  output logic        [2:0] slot,
  output logic        [3:0] selected_count,
  output logic              cache_full,
  output logic              pass_done
);
  import ssev_pkg::*;

  sprite_rec_t  rec;
  logic         rec_valid;
  logic         hit;
  logic         out_free;
  logic         advance;
  eval_result_t eval;
  eval_result_t res;

  assign out_free = !out_valid || out_ready;
  assign advance  = rec_valid && out_free;
  assign in_ready = !rec_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (in_ready) begin
      rec_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      rec.scanline       <= scanline;
      rec.wanted_type    <= wanted_type;
      rec.sprite_x       <= sprite_x;
      rec.sprite_y       <= sprite_y;
      rec.sprite_width   <= sprite_width;
      rec.sprite_height  <= sprite_height;
      rec.sprite_enabled <= sprite_enabled;
      rec.double_size    <= double_size;
      rec.sprite_type    <= sprite_type;
      rec.window_bits    <= window_bits;
      rec.first_sprite   <= first_sprite;
      rec.last_sprite    <= last_sprite;
    end
  end

  ssev_match #(
    .LINE_PIXELS(LINE_PIXELS)
  ) u_match (
    .rec(rec),
    .hit(hit)
  );

  ssev_count #(
    .CACHE_SLOTS(CACHE_SLOTS)
  ) u_count (
    .clk    (clk),
    .rst    (rst),
    .advance(advance),
    .first  (rec.first_sprite),
    .hit    (hit),
    .result (eval)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= rec_valid;
    end
    if (advance) begin
      res       <= eval;
      pass_done <= rec.last_sprite;
    end
  end

  assign selected       = res.selected;
  assign slot           = res.slot;
  assign selected_count = res.selected_count;
  assign cache_full     = res.cache_full;

  // A selected sprite always leaves the count one past its slot.
  `ASSERT_ALWAYS(a_slot_count, clk, rst, !(out_valid && selected) || (3'(slot + 3'd1) == selected_count[2:0]), "selected slot and count disagree")
  // A record that cannot move on must still be held in the input register.
  `ASSERT_NEXT(a_rec_hold, clk, rst, rec_valid && !out_free, rec_valid && out_valid, "held record lost")
  // An empty slot field is reported for every sprite that was not selected.
  `ASSERT_ALWAYS(a_slot_zero, clk, rst, !(out_valid && !selected) || (slot == 3'd0), "slot set on unselected sprite")

endmodule
`default_nettype wire
